// ===== rtl/ehh_pkg.sv =====
// Shared widths, codes and types of the equal-height histogram builder.
package ehh_pkg;

   localparam int DEF_MAX_BUCKETS = 256;
   localparam int DEF_VALUE_BITS  = 32;

   localparam int COUNT_BITS     = 32;
   localparam int LIMIT_BITS     = 9;
   localparam int INDEX_BITS     = 8;
   localparam int TOP_BITS       = 32;
   localparam int TOTAL_BITS     = 41;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(16);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_COUNT    = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUCKET_LIMIT = 1'b1;

   localparam logic REQ_BUILD = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic ANS_BUILD = 1'b0;
   localparam logic ANS_QUERY = 1'b1;

   typedef struct packed {
      logic                  done;
      logic [COUNT_BITS-1:0] height;
   } div_result_type;

endpackage

// ===== rtl/ehh_div.sv =====
// Iterative restoring divider giving the rounded-up bucket height.
module ehh_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ehh_pkg::COUNT_BITS-1:0]    dividend,
   input  logic [ehh_pkg::LIMIT_BITS-1:0]    divisor,
   output ehh_pkg::div_result_type           result
);
   import ehh_pkg::*;

   localparam int CW = $clog2(COUNT_BITS);

   logic                  busy_ff, busy_in;
   logic                  fin_ff, fin_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         step_ff, step_in;
   logic [LIMIT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] quo_ff, quo_in;
   logic [LIMIT_BITS-1:0] dsr_ff, dsr_in;
   logic [COUNT_BITS-1:0] height_ff, height_in;
   logic [LIMIT_BITS:0]   trial;
   logic [LIMIT_BITS:0]   diff;

   assign trial = {rem_ff, quo_ff[COUNT_BITS-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in   = busy_ff;
      fin_in    = 1'b0;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      height_in = height_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[LIMIT_BITS-1:0];
            quo_in = {quo_ff[COUNT_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[LIMIT_BITS-1:0];
            quo_in = {quo_ff[COUNT_BITS-2:0], 1'b0};
         end
         step_in = step_ff + CW'(1);
         if (step_ff == CW'(COUNT_BITS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         height_in = quo_ff + COUNT_BITS'(rem_ff != '0);
         done_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      dsr_ff    <= dsr_in;
      height_ff <= height_in;
   end

   assign result.done   = done_ff;
   assign result.height = height_ff;

endmodule

// ===== rtl/ehh_store.sv =====
// Bucket maximum and distinct-count memories with one write and one registered read port.
module ehh_store #(
   parameter int MAX_BUCKETS = ehh_pkg::DEF_MAX_BUCKETS,
   parameter int VALUE_BITS  = ehh_pkg::DEF_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(MAX_BUCKETS)-1:0]      wr_addr,
   input  logic [VALUE_BITS-1:0]               wr_top,
   input  logic [ehh_pkg::COUNT_BITS-1:0]      wr_distinct,
   input  logic [$clog2(MAX_BUCKETS)-1:0]      rd_addr,
   output logic [VALUE_BITS-1:0]               rd_top,
   output logic [ehh_pkg::COUNT_BITS-1:0]      rd_distinct
);
   import ehh_pkg::*;

   logic [VALUE_BITS-1:0] top_mem [MAX_BUCKETS];
   logic [COUNT_BITS-1:0] distinct_mem [MAX_BUCKETS];
   logic [VALUE_BITS-1:0] rd_top_ff;
   logic [COUNT_BITS-1:0] rd_distinct_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         top_mem[wr_addr]      <= wr_top;
         distinct_mem[wr_addr] <= wr_distinct;
      end
      rd_top_ff      <= top_mem[rd_addr];
      rd_distinct_ff <= distinct_mem[rd_addr];
   end

   assign rd_top      = rd_top_ff;
   assign rd_distinct = rd_distinct_ff;

endmodule

// ===== rtl/equal_height_histogram_builder_core.sv =====
// Top level of the equal-height histogram builder: sequencer, shared compare unit, registers.
//
//   channel  direction  handshake              beat contents
//   req      in         req_valid / req_stall  req_type, req_value, req_count, req_last
//   rsp      out        rsp_valid / rsp_stall  answer_kind .. overflow, one beat per result
//   csr      in         csr_write              csr_index, csr_wdata
//
// One item is taken at a time; req_stall is high from acceptance until the item is done.
// A build item that opens a build first waits in ST_DIV for the 32-step divider, then runs
// ST_ACCUM and ST_DECIDE; any other build item runs ST_ACCUM and ST_DECIDE only. A query
// runs ST_QINIT, then two binary searches through the single memory read port of up to
// log2(MAX_BUCKETS)+1 ST_QREAD/ST_QCMP probes each, then ST_QFETCH and ST_QOUT.
// Reset is synchronous and clears the table; no memory sweep is done.
// A result beat waiting under rsp_stall holds the sequencer in its final state only.
module equal_height_histogram_builder_core #(
   parameter int MAX_BUCKETS = ehh_pkg::DEF_MAX_BUCKETS,
   parameter int VALUE_BITS  = ehh_pkg::DEF_VALUE_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [ehh_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ehh_pkg::COUNT_BITS-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic signed [VALUE_BITS-1:0]         req_value,
   input  logic [ehh_pkg::COUNT_BITS-1:0]       req_count,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_answer_kind,
   output logic [ehh_pkg::INDEX_BITS-1:0]       rsp_bucket_index,
   output logic signed [ehh_pkg::TOP_BITS-1:0]  rsp_bucket_top,
   output logic [ehh_pkg::COUNT_BITS-1:0]       rsp_bucket_distinct,
   output logic                                 rsp_lower_valid,
   output logic                                 rsp_in_range,
   output logic [ehh_pkg::INDEX_BITS-1:0]       rsp_upper_index,
   output logic                                 rsp_upper_valid,
   output logic [ehh_pkg::TOTAL_BITS-1:0]       rsp_total_rows,
   output logic                                 rsp_overflow
);
   import ehh_pkg::*;

   localparam int AW = $clog2(MAX_BUCKETS);
   localparam int TW = $clog2(MAX_BUCKETS + 1);
   localparam int IW = (TW > INDEX_BITS) ? TW : INDEX_BITS;
   localparam int WW = (VALUE_BITS > TOP_BITS) ? VALUE_BITS : TOP_BITS;
   localparam logic [TW-1:0] CAP     = TW'(MAX_BUCKETS);
   localparam logic [IW-1:0] IDX_MAX = IW'((1 << INDEX_BITS) - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DIV    = 4'd1;
   localparam logic [3:0] ST_ACCUM  = 4'd2;
   localparam logic [3:0] ST_DECIDE = 4'd3;
   localparam logic [3:0] ST_QINIT  = 4'd4;
   localparam logic [3:0] ST_QREAD  = 4'd5;
   localparam logic [3:0] ST_QCMP   = 4'd6;
   localparam logic [3:0] ST_QFETCH = 4'd7;
   localparam logic [3:0] ST_QOUT   = 4'd8;

   logic [COUNT_BITS-1:0] row_count_ff;
   logic [LIMIT_BITS-1:0] limit_ff;

   logic [3:0]             state_ff, state_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   last_ff, last_in;
   logic                   build_open_ff, build_open_in;
   logic                   overflow_ff, overflow_in;
   logic [TW-1:0]          bucket_total_ff, bucket_total_in;
   logic [TOTAL_BITS-1:0]  total_ff, total_in;
   logic [COUNT_BITS-1:0]  height_ff, height_in;
   logic [COUNT_BITS-1:0]  run_height_ff, run_height_in;
   logic [COUNT_BITS-1:0]  run_distinct_ff, run_distinct_in;
   logic signed [VALUE_BITS-1:0] low_value_ff, low_value_in;
   logic [TW-1:0]          lo_ff, lo_in;
   logic [TW-1:0]          hi_ff, hi_in;
   logic [TW-1:0]          ub_ff, ub_in;
   logic                   strict_ff, strict_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [INDEX_BITS-1:0]  rsp_index_ff, rsp_index_in;
   logic [TOP_BITS-1:0]    rsp_top_ff, rsp_top_in;
   logic [COUNT_BITS-1:0]  rsp_distinct_ff, rsp_distinct_in;
   logic                   rsp_lvalid_ff, rsp_lvalid_in;
   logic                   rsp_inrange_ff, rsp_inrange_in;
   logic [INDEX_BITS-1:0]  rsp_uindex_ff, rsp_uindex_in;
   logic                   rsp_uvalid_ff, rsp_uvalid_in;
   logic [TOTAL_BITS-1:0]  rsp_total_ff, rsp_total_in;
   logic                   rsp_ovf_ff, rsp_ovf_in;

   logic                   req_accept;
   logic                   out_free;
   logic                   div_start;
   logic [LIMIT_BITS-1:0]  divisor;
   div_result_type         div_res;
   logic [TW:0]            mid_sum;
   logic [TW-1:0]          mid;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [VALUE_BITS-1:0]  rd_top;
   logic [COUNT_BITS-1:0]  rd_distinct;
   logic [COUNT_BITS:0]    height_sum;
   logic                   go_right;
   logic                   close;
   logic                   lv;
   logic                   uv;
   logic [IW-1:0]          total_ext;
   logic [IW-1:0]          lo_ext;
   logic [IW-1:0]          ub_ext;
   logic [WW-1:0]          value_wide;
   logic [WW-1:0]          rd_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         limit_ff     <= LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ROW_COUNT: begin
               row_count_ff <= csr_wdata;
            end
            CSR_BUCKET_LIMIT: begin
               limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign div_start = req_accept && (req_type == REQ_BUILD) && !build_open_ff;
   assign divisor   = (limit_ff == '0) ? LIMIT_BITS'(1) : limit_ff;

   ehh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (row_count_ff),
      .divisor  (divisor),
      .result   (div_res)
   );

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[TW:1];
   assign rd_addr = ((state_ff == ST_QFETCH) || (state_ff == ST_QOUT)) ?
                    lo_ff[AW-1:0] : mid[AW-1:0];
   assign wr_en   = (state_ff == ST_DECIDE) && close && out_free &&
                    (bucket_total_ff != CAP);

   ehh_store #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_store (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_addr     (bucket_total_ff[AW-1:0]),
      .wr_top      (value_ff),
      .wr_distinct (run_distinct_ff),
      .rd_addr     (rd_addr),
      .rd_top      (rd_top),
      .rd_distinct (rd_distinct)
   );

   assign height_sum = {1'b0, run_height_ff} + {1'b0, count_ff};
   assign go_right   = strict_ff ? ($signed(rd_top) <= value_ff) :
                                   ($signed(rd_top) < value_ff);
   assign close      = (run_height_ff >= height_ff) ||
                       (last_ff && (run_height_ff != '0));
   assign lv         = (lo_ff < bucket_total_ff);
   assign uv         = (ub_ff < bucket_total_ff);
   assign total_ext  = IW'(bucket_total_ff);
   assign lo_ext     = IW'(lo_ff);
   assign ub_ext     = IW'(ub_ff);
   assign value_wide = WW'($unsigned(value_ff));
   assign rd_wide    = WW'(rd_top);

   always_comb begin
      state_in        = state_ff;
      value_in        = value_ff;
      count_in        = count_ff;
      last_in         = last_ff;
      build_open_in   = build_open_ff;
      overflow_in     = overflow_ff;
      bucket_total_in = bucket_total_ff;
      total_in        = total_ff;
      height_in       = height_ff;
      run_height_in   = run_height_ff;
      run_distinct_in = run_distinct_ff;
      low_value_in    = low_value_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      ub_in           = ub_ff;
      strict_in       = strict_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_kind_in     = rsp_kind_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_top_in      = rsp_top_ff;
      rsp_distinct_in = rsp_distinct_ff;
      rsp_lvalid_in   = rsp_lvalid_ff;
      rsp_inrange_in  = rsp_inrange_ff;
      rsp_uindex_in   = rsp_uindex_ff;
      rsp_uvalid_in   = rsp_uvalid_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_ovf_in      = rsp_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               value_in = req_value;
               count_in = req_count;
               last_in  = req_last;
               if (req_type == REQ_QUERY) begin
                  state_in = ST_QINIT;
               end else if (!build_open_ff) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_ACCUM;
               end
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               height_in       = div_res.height;
               bucket_total_in = '0;
               total_in        = '0;
               run_height_in   = '0;
               run_distinct_in = '0;
               overflow_in     = 1'b0;
               low_value_in    = value_ff;
               build_open_in   = 1'b1;
               state_in        = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            run_height_in = height_sum[COUNT_BITS] ? '1 : height_sum[COUNT_BITS-1:0];
            if (run_distinct_ff != '1) begin
               run_distinct_in = run_distinct_ff + COUNT_BITS'(1);
            end
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!close) begin
               if (last_ff) begin
                  build_open_in = 1'b0;
               end
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = ANS_BUILD;
               rsp_index_in    = (total_ext > IDX_MAX) ? '1 : total_ext[INDEX_BITS-1:0];
               rsp_top_in      = value_wide[TOP_BITS-1:0];
               rsp_distinct_in = run_distinct_ff;
               rsp_lvalid_in   = 1'b0;
               rsp_inrange_in  = 1'b0;
               rsp_uindex_in   = '0;
               rsp_uvalid_in   = 1'b0;
               if (bucket_total_ff == CAP) begin
                  overflow_in  = 1'b1;
                  rsp_ovf_in   = 1'b1;
                  rsp_total_in = total_ff;
               end else begin
                  bucket_total_in = bucket_total_ff + TW'(1);
                  total_in        = total_ff + TOTAL_BITS'(height_ff);
                  rsp_ovf_in      = overflow_ff;
                  rsp_total_in    = total_ff + TOTAL_BITS'(height_ff);
               end
               run_height_in   = '0;
               run_distinct_in = '0;
               if (last_ff) begin
                  build_open_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_QINIT: begin
            lo_in     = '0;
            hi_in     = bucket_total_ff;
            strict_in = 1'b1;
            state_in  = ST_QREAD;
         end
         ST_QREAD: begin
            if (lo_ff < hi_ff) begin
               state_in = ST_QCMP;
            end else if (strict_ff) begin
               ub_in     = lo_ff;
               lo_in     = '0;
               hi_in     = bucket_total_ff;
               strict_in = 1'b0;
            end else begin
               state_in = ST_QFETCH;
            end
         end
         ST_QCMP: begin
            if (go_right) begin
               lo_in = mid + TW'(1);
            end else begin
               hi_in = mid;
            end
            state_in = ST_QREAD;
         end
         ST_QFETCH: begin
            state_in = ST_QOUT;
         end
         ST_QOUT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_kind_in     = ANS_QUERY;
               rsp_index_in    = lv ? lo_ext[INDEX_BITS-1:0] : '0;
               rsp_top_in      = lv ? rd_wide[TOP_BITS-1:0] : '0;
               rsp_distinct_in = lv ? rd_distinct : '0;
               rsp_lvalid_in   = lv;
               rsp_inrange_in  = lv && (value_ff >= low_value_ff);
               rsp_uindex_in   = uv ? ub_ext[INDEX_BITS-1:0] : '0;
               rsp_uvalid_in   = uv;
               rsp_total_in    = total_ff;
               rsp_ovf_in      = overflow_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         build_open_ff   <= 1'b0;
         overflow_ff     <= 1'b0;
         bucket_total_ff <= '0;
         total_ff        <= '0;
         height_ff       <= '0;
         run_height_ff   <= '0;
         run_distinct_ff <= '0;
         low_value_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         build_open_ff   <= build_open_in;
         overflow_ff     <= overflow_in;
         bucket_total_ff <= bucket_total_in;
         total_ff        <= total_in;
         height_ff       <= height_in;
         run_height_ff   <= run_height_in;
         run_distinct_ff <= run_distinct_in;
         low_value_ff    <= low_value_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      value_ff        <= value_in;
      count_ff        <= count_in;
      last_ff         <= last_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      ub_ff           <= ub_in;
      strict_ff       <= strict_in;
      rsp_kind_ff     <= rsp_kind_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_top_ff      <= rsp_top_in;
      rsp_distinct_ff <= rsp_distinct_in;
      rsp_lvalid_ff   <= rsp_lvalid_in;
      rsp_inrange_ff  <= rsp_inrange_in;
      rsp_uindex_ff   <= rsp_uindex_in;
      rsp_uvalid_ff   <= rsp_uvalid_in;
      rsp_total_ff    <= rsp_total_in;
      rsp_ovf_ff      <= rsp_ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_answer_kind     = rsp_kind_ff;
   assign rsp_bucket_index    = rsp_index_ff;
   assign rsp_bucket_top      = rsp_top_ff;
   assign rsp_bucket_distinct = rsp_distinct_ff;
   assign rsp_lower_valid     = rsp_lvalid_ff;
   assign rsp_in_range        = rsp_inrange_ff;
   assign rsp_upper_index     = rsp_uindex_ff;
   assign rsp_upper_valid     = rsp_uvalid_ff;
   assign rsp_total_rows      = rsp_total_ff;
   assign rsp_overflow        = rsp_ovf_ff;

endmodule

// ===== rtl/ehh_checker.sv =====
// Port-level checker for the equal-height histogram builder, bound to the top level.
module ehh_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_answer_kind,
   input logic [ehh_pkg::INDEX_BITS-1:0]     rsp_bucket_index,
   input logic                               rsp_lower_valid,
   input logic                               rsp_in_range,
   input logic [ehh_pkg::INDEX_BITS-1:0]     rsp_upper_index,
   input logic                               rsp_upper_valid
);
   import ehh_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in flight");

   a_build_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_answer_kind == ANS_BUILD) |->
         !rsp_lower_valid && !rsp_in_range && !rsp_upper_valid &&
         (rsp_upper_index == '0))
      else $error("build beat carries query fields");

   a_query_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_in_range || rsp_upper_valid || (rsp_bucket_index != '0)) &&
      (rsp_answer_kind == ANS_QUERY) |-> rsp_lower_valid)
      else $error("query beat without lower bound");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result beat without an item in flight");

endmodule

bind equal_height_histogram_builder_core ehh_checker u_ehh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_answer_kind  (rsp_answer_kind),
   .rsp_bucket_index (rsp_bucket_index),
   .rsp_lower_valid  (rsp_lower_valid),
   .rsp_in_range     (rsp_in_range),
   .rsp_upper_index  (rsp_upper_index),
   .rsp_upper_valid  (rsp_upper_valid)
);
